FILE: sv/rsc_pkg.sv
package rsc_pkg;

  // Stack geometry and data width
  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);

  // Command codes
  localparam logic [3:0] ACT_PUSH  = 4'd0;
  localparam logic [3:0] ACT_ADD   = 4'd1;
  localparam logic [3:0] ACT_SUB   = 4'd2;
  localparam logic [3:0] ACT_MUL   = 4'd3;
  localparam logic [3:0] ACT_DIV   = 4'd4;
  localparam logic [3:0] ACT_DROP  = 4'd5;
  localparam logic [3:0] ACT_CLEAR = 4'd6;
  localparam logic [3:0] ACT_SWAP  = 4'd7;
  localparam logic [3:0] ACT_DUP   = 4'd8;
  localparam logic [3:0] ACT_PEEK  = 4'd9;
  localparam logic [3:0] ACT_DUMP  = 4'd10;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FEW      = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Cell operations: hold, load the shared bus, take from the cell above
  // (toward the top), take from the cell below
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_LOAD = 2'd1;
  localparam cell_op_t CELL_DOWN = 2'd2;
  localparam cell_op_t CELL_UP   = 2'd3;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t quotient;
  } div_rsp_t;

endpackage

FILE: sv/rsc_cmd_if.sv
interface rsc_cmd_if import rsc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [3:0]                   action;
  logic signed [DATA_WIDTH-1:0] operand;

  modport source (output valid, action, operand, input ready);
  modport sink   (input valid, action, operand, output ready);
endinterface

FILE: sv/rsc_res_if.sv
interface rsc_res_if import rsc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         value_valid;
  logic [2:0]                   status;
  logic                         last;
  logic [CNT_W-1:0]             entries;

  modport source (output valid, value, value_valid, status, last, entries, input ready);
  modport sink   (input valid, value, value_valid, status, last, entries, output ready);
endinterface

FILE: sv/rpn_stack_calculator_core.sv
// Channel   Dir  Payload                                      Transfer
// in_cmd    in   action[3:0], operand[31:0] signed            valid && ready
// out_res   out  value[31:0] signed, value_valid, status[2:0], valid && ready
//                last, entries[4:0]
//
// One command at a time. Push, add, sub, drop, clear, swap, dup, peek and
// error results are registered from the execute state; mul and div go on to
// write-back, div by way of the one-bit-per-cycle divider. Dump rotates the
// cell chain once per cycle while no result stalls, once round the chain.
// Reset (rst_n low, synchronous) empties the stack; entries hold no reset.
// A stalled result holds the output register; the next command is taken
// meanwhile and waits until the register frees.
module rpn_stack_calculator_core import rsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rsc_cmd_if.sink   in_cmd,
  rsc_res_if.source out_res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DUMP = 3'd4;

  logic [2:0]       state_r,     state_nxt;
  logic [3:0]       act_r,       act_nxt;
  data_t            opnd_r,      opnd_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  data_t            res_r,       res_nxt;
  logic [IDX_W-1:0] idx_r,       idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  data_t            out_value_r, out_value_nxt;
  logic             out_vv_r,    out_vv_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic             out_last_r,  out_last_nxt;
  logic [CNT_W-1:0] out_entries_r, out_entries_nxt;

  cell_op_t         cell_op [STACK_DEPTH];
  data_t            cell_q  [STACK_DEPTH];
  data_t            cell_push;
  data_t            cell_ld;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             out_free;
  logic             in_xfer;
  logic             empty;
  logic             full;
  logic             in_range;
  data_t            top;
  data_t            sec;
  data_t            prod;

  // Chain of entry cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    data_t prev_d;
    data_t next_d;
    if (i == 0) begin : g_first
      assign prev_d = cell_push;
    end else begin : g_mid_prev
      assign prev_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_d = cell_q[0];
    end else begin : g_mid_next
      assign next_d = cell_q[i+1];
    end
    rsc_cell u_cell (
      .clk    (clk),
      .op     (cell_op[i]),
      .prev_d (prev_d),
      .next_d (next_d),
      .load_d (cell_ld),
      .q      (cell_q[i])
    );
  end

  rsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign top      = cell_q[0];
  assign sec      = cell_q[1];
  assign prod     = sec * top;
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));
  assign in_range = (CNT_W'(idx_r) < cnt_r);
  assign out_free = !out_valid_r || out_res.ready;
  assign in_xfer  = in_cmd.valid && in_cmd.ready;

  assign in_cmd.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    opnd_nxt        = opnd_r;
    cnt_nxt         = cnt_r;
    res_nxt         = res_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r && !out_res.ready;
    out_value_nxt   = out_value_r;
    out_vv_nxt      = out_vv_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    out_entries_nxt = out_entries_r;
    cell_push       = opnd_r;
    cell_ld         = res_r;
    div_req.start    = 1'b0;
    div_req.dividend = sec;
    div_req.divisor  = top;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end

    unique case (state_r)
      S_IDLE: begin
        // Latch the command
        if (in_xfer) begin
          act_nxt   = in_cmd.action;
          opnd_nxt  = in_cmd.operand;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          // Default single result, status ok
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_vv_nxt     = 1'b0;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          unique case (act_r) inside
            ACT_PUSH: begin
              if (full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                for (int i = 0; i < STACK_DEPTH; i++) cell_op[i] = CELL_DOWN;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_SWAP: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else if (cnt_r == CNT_W'(1)) begin
                out_status_nxt = ST_FEW;
              end else if (act_r == ACT_SWAP) begin
                cell_op[0] = CELL_UP;
                cell_op[1] = CELL_DOWN;
              end else if (act_r == ACT_MUL) begin
                // Register the product, write back next cycle
                res_nxt       = prod;
                out_valid_nxt = 1'b0;
                state_nxt     = S_WB;
              end else if (act_r == ACT_DIV) begin
                if (top == '0) begin
                  out_status_nxt = ST_DIVZERO;
                end else begin
                  div_req.start = 1'b1;
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_DIV;
                end
              end else begin
                // Add or subtract: pop one, result replaces the new top
                cell_ld    = (act_r == ACT_ADD) ? (sec + top) : (sec - top);
                cell_op[0] = CELL_LOAD;
                for (int i = 1; i < STACK_DEPTH; i++) cell_op[i] = CELL_UP;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            ACT_DROP: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                for (int i = 0; i < STACK_DEPTH; i++) cell_op[i] = CELL_UP;
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            ACT_CLEAR: begin
              if (empty) out_status_nxt = ST_EMPTY;
              else       cnt_nxt = '0;
            end
            ACT_DUP: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else if (full) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                cell_push = top;
                for (int i = 0; i < STACK_DEPTH; i++) cell_op[i] = CELL_DOWN;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_PEEK: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_value_nxt = top;
                out_vv_nxt    = 1'b1;
              end
            end
            ACT_DUMP: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                idx_nxt       = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
          out_entries_nxt = cnt_nxt;
        end
      end

      S_DIV: begin
        // Wait for the quotient
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quotient;
          state_nxt = S_WB;
        end
      end

      S_WB: begin
        // Pop one, registered result replaces the new top
        cell_op[0] = CELL_LOAD;
        for (int i = 1; i < STACK_DEPTH; i++) cell_op[i] = CELL_UP;
        cnt_nxt         = cnt_r - 1'b1;
        out_valid_nxt   = 1'b1;
        out_value_nxt   = '0;
        out_vv_nxt      = 1'b0;
        out_status_nxt  = ST_OK;
        out_last_nxt    = 1'b1;
        out_entries_nxt = cnt_r - 1'b1;
        state_nxt       = S_IDLE;
      end

      S_DUMP: begin
        // Rotate the whole chain once round, sending the live entries
        if (!in_range || out_free) begin
          for (int i = 0; i < STACK_DEPTH; i++) cell_op[i] = CELL_UP;
          if (in_range) begin
            out_valid_nxt   = 1'b1;
            out_value_nxt   = top;
            out_vv_nxt      = 1'b1;
            out_status_nxt  = ST_OK;
            out_last_nxt    = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
            out_entries_nxt = cnt_r;
          end
          if (idx_r == IDX_W'(STACK_DEPTH - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r         <= act_nxt;
    opnd_r        <= opnd_nxt;
    res_r         <= res_nxt;
    idx_r         <= idx_nxt;
    out_value_r   <= out_value_nxt;
    out_vv_r      <= out_vv_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
    out_entries_r <= out_entries_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.value       = out_value_r;
  assign out_res.value_valid = out_vv_r;
  assign out_res.status      = out_status_r;
  assign out_res.last        = out_last_r;
  assign out_res.entries     = out_entries_r;

endmodule

FILE: sv/rsc_cell.sv
module rsc_cell import rsc_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  data_t    prev_d,
  input  data_t    next_d,
  input  data_t    load_d,
  output data_t    q
);

  data_t q_r;
  data_t q_nxt;

  // Select the next entry value from the neighbors or the shared bus
  always_comb begin
    case (op)
      CELL_LOAD: q_nxt = load_d;
      CELL_DOWN: q_nxt = prev_d;
      CELL_UP:   q_nxt = next_d;
      default:   q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: sv/rsc_div.sv
module rsc_div import rsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r,  busy_nxt;
  logic [DIV_CNT_W-1:0] step_r,  step_nxt;
  logic                 neg_r,   neg_nxt;
  data_t                rem_r,   rem_nxt;
  data_t                quo_r,   quo_nxt;
  data_t                dvs_r,   dvs_nxt;

  data_t                rem_sh;
  logic [DATA_WIDTH:0]  diff;
  logic                 finish;

  // Shift in one dividend bit and try the subtraction
  assign rem_sh = {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign finish = busy_r && (step_r == DIV_CNT_W'(DATA_WIDTH));

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (!busy_r && req.start) begin
      // Load magnitudes and remember the quotient sign
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = req.dividend[DATA_WIDTH-1] ^ req.divisor[DATA_WIDTH-1];
      rem_nxt  = '0;
      quo_nxt  = req.dividend[DATA_WIDTH-1] ? (~req.dividend + 1'b1) : req.dividend;
      dvs_nxt  = req.divisor[DATA_WIDTH-1] ? (~req.divisor + 1'b1) : req.divisor;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      // One restoring step per cycle
      step_nxt = step_r + 1'b1;
      if (!diff[DATA_WIDTH]) begin
        rem_nxt = diff[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = finish;
  assign rsp.quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import rsc_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_CMDS  = 155;
  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_TIME  = 48;

  // Codes the block leaves unused
  localparam logic [3:0] ACT_SPARE_LO = 4'd11;
  localparam logic [3:0] ACT_SPARE_HI = 4'd15;

  localparam data_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam data_t MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t MINUS_ONE = '1;

  typedef struct packed {
    data_t            value;
    logic             value_valid;
    logic [2:0]       status;
    logic             last;
    logic [CNT_W-1:0] entries;
  } stack_res_t;

  typedef struct packed {
    logic [3:0] action;
    data_t      operand;
    logic       fixed;
    stack_res_t want;
  } cmd_row_t;

  logic clk;
  logic rst_n;

  rsc_cmd_if cmd_if ();
  rsc_res_if res_if ();

  rpn_stack_calculator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_if.sink),
    .out_res(res_if.source)
  );

  // Shadow copy of the stack
  data_t stack_img [STACK_DEPTH];
  int    depth_img = 0;

  stack_res_t  pending_results[$];
  cmd_row_t    directed_rows[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Signed divide, truncating toward zero; the most negative value over minus one wraps
  function automatic data_t trunc_quotient(input data_t num, input data_t den);
    data_t mag_n;
    data_t mag_d;
    data_t q;
    mag_n = num[DATA_WIDTH-1] ? -num : num;
    mag_d = den[DATA_WIDTH-1] ? -den : den;
    q = mag_n / mag_d;
    return (num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1]) ? -q : q;
  endfunction

  // Apply one command to the shadow stack and queue the results it yields
  task automatic predict_stack(input logic [3:0] act, input data_t opd);
    stack_res_t r;
    data_t      top;
    data_t      sec;
    data_t      acc;
    int         i;
    r = '0;
    r.last = 1'b1;
    r.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (depth_img >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          stack_img[depth_img] = opd;
          depth_img++;
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_SWAP: begin
        if (depth_img == 0) begin
          r.status = ST_EMPTY;
        end else if (depth_img == 1) begin
          r.status = ST_FEW;
        end else begin
          top = stack_img[depth_img-1];
          sec = stack_img[depth_img-2];
          if (act == ACT_SWAP) begin
            stack_img[depth_img-1] = sec;
            stack_img[depth_img-2] = top;
          end else if (act == ACT_DIV && top == '0) begin
            r.status = ST_DIVZERO;
          end else begin
            case (act)
              ACT_ADD: acc = sec + top;
              ACT_SUB: acc = sec - top;
              ACT_MUL: acc = sec * top;
              default: acc = trunc_quotient(sec, top);
            endcase
            depth_img--;
            stack_img[depth_img-1] = acc;
          end
        end
      end
      ACT_DROP: begin
        if (depth_img == 0) r.status = ST_EMPTY;
        else depth_img--;
      end
      ACT_CLEAR: begin
        if (depth_img == 0) r.status = ST_EMPTY;
        else depth_img = 0;
      end
      ACT_DUP: begin
        if (depth_img == 0) begin
          r.status = ST_EMPTY;
        end else if (depth_img >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          stack_img[depth_img] = stack_img[depth_img-1];
          depth_img++;
        end
      end
      ACT_PEEK: begin
        if (depth_img == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = stack_img[depth_img-1];
          r.value_valid = 1'b1;
        end
      end
      ACT_DUMP: begin
        if (depth_img == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // One result per entry, top first
          for (i = depth_img - 1; i >= 0; i--) begin
            r.value = stack_img[i];
            r.value_valid = 1'b1;
            r.last = (i == 0);
            r.entries = depth_img[CNT_W-1:0];
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.entries = depth_img[CNT_W-1:0];
    pending_results.push_back(r);
  endtask

  task automatic add_row(input logic [3:0] act, input data_t opd, input logic fixed,
                         input data_t value, input logic value_valid,
                         input logic [2:0] status, input int entries);
    cmd_row_t row;
    row.action = act;
    row.operand = opd;
    row.fixed = fixed;
    row.want.value = value;
    row.want.value_valid = value_valid;
    row.want.status = status;
    row.want.last = 1'b1;
    row.want.entries = entries[CNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // Send one command in bursts; a fixed row replaces the predicted result
  task automatic send_cmd(input logic [3:0] act, input data_t opd, input logic fixed,
                          input stack_res_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(10, 1);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(7, 0) == 0) ? 30 : $urandom_range(8, 1);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.action <= act;
    cmd_if.operand <= opd;
    do @(posedge clk); while (!cmd_if.ready);
    predict_stack(act, opd);
    if (fixed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
    burst_left--;
  endtask

  function automatic data_t pick_operand();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return data_t'(1);
      2:       return MINUS_ONE;
      3:       return MOST_NEG;
      4:       return MOST_POS;
      5, 6:    return data_t'($urandom_range(40, 0)) - data_t'(20);
      default: return data_t'($urandom);
    endcase
  endfunction

  // Fill mode grows the stack toward full; otherwise mostly consume entries
  function automatic logic [3:0] pick_action(input logic filling);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (filling) return (roll < 88) ? ACT_PUSH : ACT_DUP;
    if (roll < 4)  return ACT_CLEAR;
    if (roll < 8)  return 4'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    if (roll < 16) return ACT_DUMP;
    if (roll < 24) return ACT_PEEK;
    if (roll < 34) return ACT_ADD;
    if (roll < 44) return ACT_SUB;
    if (roll < 54) return ACT_MUL;
    if (roll < 68) return ACT_DIV;
    if (roll < 76) return ACT_SWAP;
    if (roll < 84) return ACT_DROP;
    if (roll < 88) return ACT_DUP;
    return ACT_PUSH;
  endfunction

  // Stimulus
  initial begin
    logic [3:0] act;
    int         mode_left;
    logic       filling;
    int         n;
    rst_n <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.action <= ACT_PUSH;
    cmd_if.operand <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty stack, then the extremes of divide, then every other operation
    add_row(ACT_PEEK,     $urandom,  1'b1, '0, 1'b0, ST_EMPTY, 0);
    add_row(ACT_DUMP,     $urandom,  1'b1, '0, 1'b0, ST_EMPTY, 0);
    add_row(ACT_ADD,      $urandom,  1'b1, '0, 1'b0, ST_EMPTY, 0);
    add_row(ACT_SWAP,     $urandom,  1'b1, '0, 1'b0, ST_EMPTY, 0);
    add_row(ACT_DROP,     $urandom,  1'b1, '0, 1'b0, ST_EMPTY, 0);
    add_row(ACT_CLEAR,    $urandom,  1'b1, '0, 1'b0, ST_EMPTY, 0);
    add_row(ACT_DUP,      $urandom,  1'b1, '0, 1'b0, ST_EMPTY, 0);
    add_row(ACT_PUSH,     MOST_NEG,  1'b1, '0, 1'b0, ST_OK, 1);
    add_row(ACT_DIV,      $urandom,  1'b1, '0, 1'b0, ST_FEW, 1);
    add_row(ACT_PEEK,     $urandom,  1'b1, MOST_NEG, 1'b1, ST_OK, 1);
    add_row(ACT_PUSH,     MINUS_ONE, 1'b1, '0, 1'b0, ST_OK, 2);
    add_row(ACT_DIV,      $urandom,  1'b1, '0, 1'b0, ST_OK, 1);
    add_row(ACT_PEEK,     $urandom,  1'b1, MOST_NEG, 1'b1, ST_OK, 1);
    add_row(ACT_PUSH,     '0,        1'b1, '0, 1'b0, ST_OK, 2);
    add_row(ACT_DIV,      $urandom,  1'b1, '0, 1'b0, ST_DIVZERO, 2);
    add_row(ACT_SUB,      $urandom,  1'b0, '0, 1'b0, ST_OK, 0);
    add_row(ACT_PUSH,     MOST_POS,  1'b1, '0, 1'b0, ST_OK, 2);
    add_row(ACT_MUL,      $urandom,  1'b0, '0, 1'b0, ST_OK, 0);
    add_row(ACT_PUSH,     $urandom,  1'b0, '0, 1'b0, ST_OK, 0);
    add_row(ACT_DUP,      $urandom,  1'b0, '0, 1'b0, ST_OK, 0);
    add_row(ACT_SWAP,     $urandom,  1'b0, '0, 1'b0, ST_OK, 0);
    add_row(ACT_ADD,      $urandom,  1'b0, '0, 1'b0, ST_OK, 0);
    add_row(ACT_DUMP,     $urandom,  1'b0, '0, 1'b0, ST_OK, 0);
    add_row(ACT_SPARE_HI, MINUS_ONE, 1'b1, '0, 1'b0, ST_OK, 2);
    add_row(ACT_CLEAR,    $urandom,  1'b1, '0, 1'b0, ST_OK, 0);

    foreach (directed_rows[k]) begin
      send_cmd(directed_rows[k].action, directed_rows[k].operand,
               directed_rows[k].fixed, directed_rows[k].want);
    end

    // Random commands, in randomly chosen fill and consume phases
    mode_left = 0;
    filling = 1'b1;
    for (n = 0; n < RANDOM_CMDS; n++) begin
      if (mode_left == 0) begin
        filling = (depth_img < STACK_DEPTH / 2) ? ($urandom_range(3, 0) != 0)
                                                 : ($urandom_range(3, 0) == 0);
        mode_left = filling ? $urandom_range(22, 4) : $urandom_range(20, 4);
      end
      act = pick_action(filling);
      send_cmd(act, pick_operand(), 1'b0, '0);
      mode_left--;
    end
    cmd_if.valid <= 1'b0;

    // Drain outstanding results, then hold off for the longest latency
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result-side backpressure: alternate ready runs and stalls of random length
  initial begin
    int unsigned run_left;
    logic        level;
    run_left = 0;
    level = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        level = !level;
        if (level) run_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(12, 1);
        else run_left = $urandom_range(6, 1);
      end
      res_if.ready <= level;
      run_left--;
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    stack_res_t exp_r;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got value %h status %0d last %b",
                 $time, res_if.value, res_if.status, res_if.last);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("value", exp_r.value, res_if.value);
        check_field("value_valid", 32'(exp_r.value_valid), 32'(res_if.value_valid));
        check_field("status", 32'(exp_r.status), 32'(res_if.status));
        check_field("last", 32'(exp_r.last), 32'(res_if.last));
        check_field("entries", 32'(exp_r.entries), 32'(res_if.entries));
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: sim.f
sv/rsc_pkg.sv
sv/rsc_cmd_if.sv
sv/rsc_res_if.sv
sv/rsc_cell.sv
sv/rsc_div.sv
sv/rpn_stack_calculator_core.sv
test/tb.sv
